>>> hw/rtl/tkr_pkg.sv
// shared constants and helpers for the trie keyword recognizer
// table geometry, field widths, character class map and row addressing
// no dependencies
package tkr_pkg;

    localparam int NODE_COUNT  = 128;
    localparam int CLASS_COUNT = 37;
    localparam int TOKEN_BASE  = 128;

    localparam int NODE_W  = 7;
    localparam int CLASS_W = 6;
    localparam int VALUE_W = 8;

    localparam int TABLE_DEPTH = NODE_COUNT * CLASS_COUNT;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam logic [CLASS_W-1:0] CLASS_TERM = '0;

    // digits to 1..10, lowercase letters to 11..36, anything else to 0
    function automatic logic [CLASS_W-1:0] char_class(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h2F;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h56;
        end
        return d[CLASS_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [NODE_W-1:0] node,
                                                   input logic [CLASS_W-1:0] cls);
        return ADDR_W'(node) * ADDR_W'(CLASS_COUNT) + ADDR_W'(cls);
    endfunction

endpackage

>>> hw/rtl/tkr_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module tkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/trie_keyword_recognizer.sv
// Trie keyword recognizer: walks a loaded transition table one character per word.
// A table-write word (tuser = 0) is written from the idle state. A character word does
// the dependent read of the next node from the single table ram in LOOK. The last
// character of a symbol goes from LOOK to EMIT, through TERM when the terminator column
// must also be read, and from idle straight to EMIT when rejected before any lookup;
// the result then waits in the output register until taken. No new word is accepted
// while a finished result cannot yet be loaded into that register. Reset does not
// clear the table; it must be loaded before symbols that reach the entries are sent.
// depends on tkr_pkg and tkr_ram
module trie_keyword_recognizer
    import tkr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // char_code[7:0], entry_node[14:8], entry_class[20:15], entry_value[28:21], zeros
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,   // last_char
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // token[7:0]
    output logic        m_tuser    // matched
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_TERM = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic MODE_WRITE = 1'b0;

    logic [1:0]         state_reg, state_next;
    logic [NODE_W-1:0]  cur_node_reg, cur_node_next;
    logic               rejected_reg, rejected_next;
    logic               last_reg, last_next;
    logic [VALUE_W-1:0] tok_reg, tok_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_token_reg, m_token_next;
    logic               m_matched_reg, m_matched_next;

    logic [7:0]         in_char;
    logic [NODE_W-1:0]  in_node;
    logic [CLASS_W-1:0] in_class;
    logic [VALUE_W-1:0] in_value;
    logic               in_accept;
    logic [CLASS_W-1:0] ch_class;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic               out_free;
    logic               s_bad;

    assign in_char  = s_tdata[7:0];
    assign in_node  = s_tdata[14:8];
    assign in_class = s_tdata[20:15];
    assign in_value = s_tdata[28:21];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign ch_class  = char_class(in_char);
    assign out_free  = !m_valid_reg || m_tready;

    assign ram_we = in_accept && (s_tuser == MODE_WRITE)
                    && (32'(in_node) < 32'(NODE_COUNT))
                    && (32'(in_class) < 32'(CLASS_COUNT));
    assign ram_waddr = tbl_addr(in_node, in_class);

    // next-node value rejects on dead entry, early token or node past the table
    assign s_bad = (ram_rdata == '0)
                   || (ram_rdata[VALUE_W-1] && !last_reg)
                   || (!ram_rdata[VALUE_W-1] && (32'(ram_rdata) >= 32'(NODE_COUNT)));

    tkr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        cur_node_next  = cur_node_reg;
        rejected_next  = rejected_reg;
        last_next      = last_reg;
        tok_next       = tok_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_token_next   = m_token_reg;
        m_matched_next = m_matched_reg;
        ram_re         = 1'b0;
        ram_raddr      = tbl_addr(cur_node_reg, ch_class);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_tuser != MODE_WRITE)) begin
                    last_next = s_tlast;
                    if (!rejected_reg && (ch_class != CLASS_TERM)) begin
                        ram_re     = 1'b1;
                        state_next = ST_LOOK;
                    end else begin
                        rejected_next = 1'b1;
                        if (s_tlast) begin
                            tok_next   = '0;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_LOOK: begin
                ram_raddr = tbl_addr(ram_rdata[NODE_W-1:0], CLASS_TERM);
                if (s_bad) begin
                    rejected_next = 1'b1;
                    if (last_reg) begin
                        tok_next   = '0;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (!last_reg) begin
                    cur_node_next = ram_rdata[NODE_W-1:0];
                    state_next    = ST_IDLE;
                end else if (ram_rdata[VALUE_W-1]) begin
                    tok_next   = ram_rdata;
                    state_next = ST_EMIT;
                end else begin
                    // plain node at the end of the symbol: read its terminator column
                    ram_re     = 1'b1;
                    state_next = ST_TERM;
                end
            end
            ST_TERM: begin
                tok_next   = ram_rdata[VALUE_W-1] ? ram_rdata : '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_token_next   = tok_reg;
                    m_matched_next = (tok_reg != '0);
                    cur_node_next  = '0;
                    rejected_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_node_reg <= '0;
            rejected_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_node_reg <= cur_node_next;
            rejected_reg <= rejected_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg      <= last_next;
        tok_reg       <= tok_next;
        m_token_reg   <= m_token_next;
        m_matched_reg <= m_matched_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_token_reg;
    assign m_tuser  = m_matched_reg;

`ifndef SYNTHESIS
    a_token_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == (m_tdata != '0)) && (m_tdata == '0 || m_tdata[VALUE_W-1])))
        else $error("result word with inconsistent token and matched flag");

    a_node_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cur_node_reg) < 32'(NODE_COUNT))
        else $error("current node beyond the table");

    a_lookup_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tuser && !rejected_reg && (ch_class != CLASS_TERM))
        |=> (state_reg == ST_LOOK))
        else $error("character word did not start a table lookup");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free)
        |=> (m_tvalid && m_tdata == $past(tok_reg) && state_reg == ST_IDLE
             && cur_node_reg == '0 && !rejected_reg))
        else $error("finished symbol not handed to the output register");
`endif

endmodule

>>> sim/tb_tkr_pkg.sv
// mode codes and word field offsets shared by the recognizer testbench and its checker
// depends on nothing; the block's own constants come from tkr_pkg
package tb_tkr_pkg;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CHAR  = 1'b1;

    // input word layout, lowest bit first
    localparam int CHAR_LSB  = 0;
    localparam int NODE_LSB  = 8;
    localparam int CLASS_LSB = 15;
    localparam int VALUE_LSB = 21;

endpackage

>>> sim/tkr_token_checker.sv
// watches both streams of the trie keyword recognizer, walks its own copy of the
// table for every accepted word and compares each returned token in order
// depends on tkr_pkg and tb_tkr_pkg
module tkr_token_checker
    import tkr_pkg::*;
    import tb_tkr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          outstanding
);

    typedef struct {
        logic [VALUE_W-1:0] token;
        logic               matched;
    } token_result_t;

    logic [VALUE_W-1:0] trie_copy [NODE_COUNT][CLASS_COUNT];
    logic [7:0]         walk_node;
    logic               walk_dead;
    token_result_t      expected_tokens [$];

    function automatic logic [CLASS_W-1:0] symbol_class(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return CLASS_W'(c - 8'h30 + 8'd1);
        end
        if (c >= 8'h61 && c <= 8'h7a) begin
            return CLASS_W'(c - 8'h61 + 8'd11);
        end
        return CLASS_TERM;
    endfunction

    task automatic walk_trie(input logic mode, input logic [31:0] word, input logic is_last);
        logic [NODE_W-1:0]  e_node;
        logic [CLASS_W-1:0] e_cls;
        logic [CLASS_W-1:0] cls;
        logic [7:0]         nxt;
        logic [7:0]         tok;
        token_result_t      r;
        e_node = word[NODE_LSB +: NODE_W];
        e_cls  = word[CLASS_LSB +: CLASS_W];
        if (mode == MODE_WRITE) begin
            if (e_cls < CLASS_COUNT) begin
                trie_copy[e_node][e_cls] = word[VALUE_LSB +: VALUE_W];
            end
            return;
        end
        // once rejected, the rest of the symbol is ignored
        if (!walk_dead) begin
            cls = symbol_class(word[CHAR_LSB +: 8]);
            if (cls == CLASS_TERM) begin
                walk_dead = 1'b1;
            end else begin
                nxt = trie_copy[walk_node[NODE_W-1:0]][cls];
                if (nxt == 8'd0 || (nxt >= TOKEN_BASE && !is_last)) begin
                    walk_dead = 1'b1;
                end else begin
                    walk_node = nxt;
                end
            end
        end
        if (!is_last) begin
            return;
        end
        tok = 8'd0;
        if (!walk_dead) begin
            nxt = walk_node;
            if (nxt < TOKEN_BASE) begin
                nxt = trie_copy[nxt[NODE_W-1:0]][CLASS_TERM];
            end
            if (nxt >= TOKEN_BASE) begin
                tok = nxt;
            end
        end
        r.token   = tok;
        r.matched = (tok != 8'd0);
        expected_tokens.push_back(r);
        walk_node = 8'd0;
        walk_dead = 1'b0;
    endtask

    always @(posedge aclk) begin
        token_result_t want;
        if (!aresetn) begin
            walk_node = 8'd0;
            walk_dead = 1'b0;
            expected_tokens.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected result: token %0d, matched %0b", m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_tdata !== want.token) begin
                        $error("token: expected %0d, got %0d", want.token, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.matched) begin
                        $error("matched: expected %0b, got %0b", want.matched, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                walk_trie(s_tuser, s_tdata, s_tlast);
            end
        end
        outstanding <= expected_tokens.size();
    end

endmodule

>>> sim/tb_trie_keyword_recognizer.sv
// top of the trie keyword recognizer testbench: loads the table, sends directed and
// random symbols with random idling on both sides, and reports the verdict
// depends on tkr_pkg, tb_tkr_pkg, tkr_token_checker and the recognizer rtl
module tb_trie_keyword_recognizer;
    import tkr_pkg::*;
    import tb_tkr_pkg::*;

    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_WORDS   = 230;
    localparam int MAX_KEY_LEN    = 10;
    localparam int LIVE_ROWS      = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    int fail_count;
    int outstanding;

    // what the table holds, used only to steer symbols down live paths
    logic [VALUE_W-1:0] trie_img [NODE_COUNT][CLASS_COUNT];

    bit quiet       = 1'b1;
    bit rx_hold_req = 1'b0;
    int words_sent  = 0;

    always #5 aclk = ~aclk;

    trie_keyword_recognizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tkr_token_checker u_token_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic int idle_cycles();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] class_char(input int c);
        if (c <= 10) begin
            return 8'h30 + 8'(c - 1);
        end
        return 8'h61 + 8'(c - 11);
    endfunction

    // live rows are 0..LIVE_ROWS-2 plus the top node of the table
    function automatic logic [NODE_W-1:0] live_row(input int n);
        if (n == LIVE_ROWS - 1) begin
            return NODE_W'(NODE_COUNT - 1);
        end
        return NODE_W'(n);
    endfunction

    function automatic logic [VALUE_W-1:0] live_node();
        return VALUE_W'(live_row($urandom_range(1, LIVE_ROWS - 1)));
    endfunction

    function automatic logic [VALUE_W-1:0] fill_value(input logic [CLASS_W-1:0] cls);
        int r;
        r = $urandom_range(0, 99);
        if (cls == CLASS_TERM) begin
            if (r < 50) return VALUE_W'($urandom_range(TOKEN_BASE, 255));
            if (r < 75) return '0;
            return live_node();
        end
        if (r < 35) return '0;
        if (r < 80) return live_node();
        return VALUE_W'($urandom_range(TOKEN_BASE, 255));
    endfunction

    task automatic send_word(input logic mode, input logic [7:0] ch, input logic is_last,
                             input logic [NODE_W-1:0] node, input logic [CLASS_W-1:0] cls,
                             input logic [VALUE_W-1:0] val);
        logic [31:0] word;
        int          gap;
        word = '0;
        word[CHAR_LSB +: 8]        = ch;
        word[NODE_LSB +: NODE_W]   = node;
        word[CLASS_LSB +: CLASS_W] = cls;
        word[VALUE_LSB +: VALUE_W] = val;
        s_tuser  <= mode;
        s_tlast  <= is_last;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (mode == MODE_WRITE && cls < CLASS_COUNT) begin
            trie_img[node][cls] = val;
        end
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // unused fields of each word carry random bits
    task automatic load_entry(input logic [NODE_W-1:0] node, input logic [CLASS_W-1:0] cls,
                              input logic [VALUE_W-1:0] val);
        send_word(MODE_WRITE, 8'($urandom), 1'($urandom), node, cls, val);
    endtask

    task automatic send_char(input logic [7:0] ch, input logic is_last);
        send_word(MODE_CHAR, ch, is_last, NODE_W'($urandom), CLASS_W'($urandom),
                  VALUE_W'($urandom));
    endtask

    task automatic scribble_entry();
        logic [CLASS_W-1:0] cls;
        if ($urandom_range(0, 9) == 0) begin
            cls = CLASS_W'($urandom_range(CLASS_COUNT, 63));
        end else begin
            cls = CLASS_W'($urandom_range(0, CLASS_COUNT - 1));
        end
        load_entry(NODE_W'($urandom_range(0, NODE_COUNT - 1)), cls, fill_value(cls));
    endtask

    // follows live edges of the table; spoil swaps one character for a random byte
    task automatic send_keyword(input int max_len, input bit spoil);
        logic [7:0] node;
        logic [7:0] v;
        int         picks [$];
        int         len;
        int         brk;
        int         c;
        bit         fin;
        len  = $urandom_range(1, max_len);
        brk  = spoil ? $urandom_range(0, len - 1) : -1;
        node = 8'd0;
        for (int i = 0; i < len; i++) begin
            fin = (i == len - 1);
            if ($urandom_range(0, 19) == 0) begin
                scribble_entry();
            end
            picks.delete();
            if (node < TOKEN_BASE) begin
                for (int k = 1; k < CLASS_COUNT; k++) begin
                    v = trie_img[node[NODE_W-1:0]][k];
                    if (v != 8'd0 && (fin || v < TOKEN_BASE)) begin
                        picks.push_back(k);
                    end
                end
            end
            if (i == brk || picks.size() == 0) begin
                send_char(8'($urandom), fin);
                node = 8'(TOKEN_BASE);
            end else begin
                c    = picks[$urandom_range(0, picks.size() - 1)];
                node = trie_img[node[NODE_W-1:0]][c];
                send_char(class_char(c), fin);
            end
        end
    endtask

    task automatic send_noise();
        int len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 1) == 1) begin
                send_char(class_char($urandom_range(1, CLASS_COUNT - 1)), i == len - 1);
            end else begin
                send_char(8'($urandom), i == len - 1);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // result side backpressure
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                n = RX_HOLD_CYCLES;
            end else begin
                n = idle_cycles();
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int  base;
        int  done;
        int  pick;
        bit  held;
        bit  drained;
        held    = 1'b0;
        drained = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // next values only name live rows, and every live row is written in full
        for (int n = 0; n < LIVE_ROWS; n++) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                load_entry(live_row(n), CLASS_W'(c), fill_value(CLASS_W'(c)));
            end
        end
        quiet = 1'b0;

        load_entry(7'd0, 6'd11, 8'd1);             // root --a--> 1
        load_entry(7'd1, 6'd36, 8'd127);           // 1 --z--> 127
        load_entry(7'd127, CLASS_TERM, 8'd255);
        load_entry(7'd127, 6'd10, 8'd128);         // --9--> smallest token
        load_entry(7'd0, 6'd12, 8'd0);             // b is dead at the root
        load_entry(7'd0, 6'd37, 8'd0);             // class out of range, dropped
        load_entry(7'd0, 6'd63, 8'd0);
        send_char(8'h61, 1'b0);                    // "az" ends on a terminator token
        send_char(8'h7a, 1'b1);
        send_char(8'h61, 1'b0);                    // "az9" lands on a token directly
        send_char(8'h7a, 1'b0);
        send_char(8'h39, 1'b1);
        send_char(8'h61, 1'b0);                    // token before the last word rejects
        send_char(8'h7a, 1'b0);
        send_char(8'h39, 1'b0);
        send_char(8'h61, 1'b1);
        send_char(8'h62, 1'b1);                    // dead entry
        send_char(8'hff, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'h61, 1'b0);                    // table write inside a symbol
        load_entry(7'd0, 6'd11, 8'd2);
        send_char(8'h7a, 1'b1);
        send_char(8'h7b, 1'b0);                    // bad byte, rest is ignored
        send_char(8'h61, 1'b0);
        send_char(8'h7a, 1'b1);

        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            done = words_sent - base;
            if (!held && done >= 50) begin
                held        = 1'b1;
                rx_hold_req = 1'b1;
            end
            if (!drained && done >= 110) begin
                drained = 1'b1;
                wait_drained();
            end
            quiet = (done >= 140 && done < 180);
            pick  = $urandom_range(0, 99);
            if (pick < 65) begin
                send_keyword(MAX_KEY_LEN, 1'b0);
            end else if (pick < 75) begin
                send_keyword(MAX_KEY_LEN, 1'b1);
            end else if (pick < 88) begin
                send_noise();
            end else begin
                scribble_entry();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tkr_pkg.sv
hw/rtl/tkr_ram.sv
hw/rtl/trie_keyword_recognizer.sv
sim/tb_tkr_pkg.sv
sim/tkr_token_checker.sv
sim/tb_trie_keyword_recognizer.sv
